FILE: rtl/tlafit_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlafit_pkg: shared types and constants for the arm fit error block
// Fixed-point constants, register indexes, controller states, commands and
// the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package tlafit_pkg;

    localparam int MAX_POINTS_DEF   = 256;
    localparam int CORDIC_STEPS_DEF = 18;

    localparam int GRID_W   = 5;
    localparam int IN_ANG_W = 20;
    localparam int LEN_W    = 23;
    localparam int POS_W    = 24;
    localparam int OFF_W    = 20;
    localparam int ANG_W    = 22;   // offset-corrected angle before reduction
    localparam int CW       = 34;   // CORDIC vector and angle width, Q30
    localparam int V_W      = 28;   // grid * span + 9
    localparam int Q_W      = 25;   // (grid * span + 9) / 18
    localparam int EXP_W    = 26;   // expected position
    localparam int ERR_W    = 27;   // position error
    localparam int SUM_W    = 56;
    localparam int RMS_W    = 23;
    localparam int CNT_OUT_W = 9;
    localparam int STEP_W   = 6;
    localparam int IDX_W    = 4;
    localparam int CFG_W    = 24;
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 32;

    localparam logic signed [ANG_W-1:0] PI_Q16      = 22'sd205887;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q16 = 22'sd102944;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q16  = 22'sd411775;
    localparam logic signed [CW-1:0]    GAIN_Q30    = 34'sd652032874;
    // floor(2^32 / 18), used for the division by the grid step count
    localparam logic signed [28:0]      RECIP_18    = 29'sd238609294;
    localparam logic [RMS_W-1:0]        RMS_MAX     = 23'd8388607;

    localparam logic [LEN_W-1:0] LINK_ONE_RST = 23'd90880;
    localparam logic [LEN_W-1:0] LINK_TWO_RST = 23'd78848;
    localparam logic [POS_W-1:0] ORIGIN_X_RST = 24'd28416;
    localparam logic [POS_W-1:0] ORIGIN_Y_RST = 24'hFFDB66;   // -9370
    localparam logic [LEN_W-1:0] SPAN_X_RST   = 23'd110592;
    localparam logic [LEN_W-1:0] SPAN_Y_RST   = 23'd102656;
    localparam logic [OFF_W-1:0] OFF_ONE_RST  = 20'd102944;
    localparam logic [OFF_W-1:0] OFF_TWO_RST  = 20'd205887;

    localparam logic [IDX_W-1:0] REG_LINK_ONE = 4'd0;
    localparam logic [IDX_W-1:0] REG_LINK_TWO = 4'd1;
    localparam logic [IDX_W-1:0] REG_ORIGIN_X = 4'd2;
    localparam logic [IDX_W-1:0] REG_ORIGIN_Y = 4'd3;
    localparam logic [IDX_W-1:0] REG_SPAN_X   = 4'd4;
    localparam logic [IDX_W-1:0] REG_SPAN_Y   = 4'd5;
    localparam logic [IDX_W-1:0] REG_OFF_ONE  = 4'd6;
    localparam logic [IDX_W-1:0] REG_OFF_TWO  = 4'd7;

    localparam logic [STEP_W-1:0] MUL_LAST  = 6'd10;
    localparam logic [STEP_W-1:0] DIV_LAST  = 6'd55;
    localparam logic [STEP_W-1:0] SQRT_LAST = 6'd27;

    typedef enum logic [3:0] {
        ST_IDLE, ST_REDUCE, ST_FOLD, ST_ROTATE, ST_MUL, ST_CHECK,
        ST_DIV_INIT, ST_DIV, ST_SQRT_INIT, ST_SQRT, ST_EMIT
    } state_t;

    typedef enum logic [3:0] {
        CMD_NONE, CMD_LOAD, CMD_REDUCE, CMD_FOLD, CMD_ROTATE, CMD_MUL,
        CMD_DIV_INIT, CMD_DIV, CMD_SQRT_INIT, CMD_SQRT, CMD_EMIT
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t             op;
        logic [STEP_W-1:0]   step;
    } cmd_t;

    typedef struct packed {
        logic reduce_done;
        logic full;
        logic last;
        logic out_free;
    } status_t;

    function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] idx);
        logic signed [CW-1:0] v;
        case (idx)
            5'd0:  v = 34'sh03243F6A8;
            5'd1:  v = 34'sh01DAC6705;
            5'd2:  v = 34'sh00FADBAFC;
            5'd3:  v = 34'sh007F56EA6;
            5'd4:  v = 34'sh003FEAB76;
            5'd5:  v = 34'sh001FFD55B;
            5'd6:  v = 34'sh000FFFAAA;
            5'd7:  v = 34'sh0007FFF55;
            5'd8:  v = 34'sh0003FFFEA;
            5'd9:  v = 34'sh0001FFFFD;
            5'd10: v = 34'sh0000FFFFF;
            5'd11: v = 34'sh00007FFFF;
            5'd12: v = 34'sh00003FFFF;
            5'd13: v = 34'sh00001FFFF;
            5'd14: v = 34'sh00000FFFF;
            5'd15: v = 34'sh000007FFF;
            5'd16: v = 34'sh000003FFF;
            5'd17: v = 34'sh000001FFF;
            5'd18: v = 34'sh000000FFF;
            5'd19: v = 34'sh0000007FF;
            5'd20: v = 34'sh0000003FF;
            5'd21: v = 34'sh0000001FF;
            5'd22: v = 34'sh0000000FF;
            5'd23: v = 34'sh00000007F;
            5'd24: v = 34'sh00000003F;
            5'd25: v = 34'sh00000001F;
            5'd26: v = 34'sh00000000F;
            5'd27: v = 34'sh000000007;
            5'd28: v = 34'sh000000003;
            5'd29: v = 34'sh000000001;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/tlafit_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlafit_ctrl: sequencer for the arm fit error datapath
// Steps one point through reduction, CORDIC, the multiply phases and, on the
// last point, the division and square root.
// ----------------------------------------------------------------------------
module tlafit_ctrl #(
    parameter int CORDIC_STEPS = tlafit_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    in_ready,
    input  wire tlafit_pkg::status_t status,
    output tlafit_pkg::cmd_t        cmd
);
    import tlafit_pkg::*;

    localparam logic [STEP_W-1:0] ROT_LAST = STEP_W'(CORDIC_STEPS - 1);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg + 6'd1;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = status.full ? ST_CHECK : ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                if (status.reduce_done) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                state_next = ST_ROTATE;
                step_next  = '0;
            end
            ST_ROTATE: begin
                if (step_reg == ROT_LAST) begin
                    state_next = ST_MUL;
                    step_next  = '0;
                end
            end
            ST_MUL: begin
                if (step_reg == MUL_LAST) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = status.last ? ST_DIV_INIT : ST_IDLE;
            end
            ST_DIV_INIT: begin
                state_next = ST_DIV;
                step_next  = '0;
            end
            ST_DIV: begin
                if (step_reg == DIV_LAST) begin
                    state_next = ST_SQRT_INIT;
                end
            end
            ST_SQRT_INIT: begin
                state_next = ST_SQRT;
                step_next  = '0;
            end
            ST_SQRT: begin
                if (step_reg == SQRT_LAST) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        cmd.op   = CMD_NONE;
        cmd.step = step_reg;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (s_tvalid) begin
                    cmd.op = CMD_LOAD;
                end
            end
            ST_REDUCE:    cmd.op = CMD_REDUCE;
            ST_FOLD:      cmd.op = CMD_FOLD;
            ST_ROTATE:    cmd.op = CMD_ROTATE;
            ST_MUL:       cmd.op = CMD_MUL;
            ST_DIV_INIT:  cmd.op = CMD_DIV_INIT;
            ST_DIV:       cmd.op = CMD_DIV;
            ST_SQRT_INIT: cmd.op = CMD_SQRT_INIT;
            ST_SQRT:      cmd.op = CMD_SQRT;
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.op = CMD_EMIT;
                end
            end
            default:      cmd.op = CMD_NONE;
        endcase
    end

    a_rotate_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROTATE) |-> (step_reg <= ROT_LAST))
        else $error("CORDIC step beyond configured count");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == CMD_EMIT) |-> status.out_free)
        else $error("result loaded over a pending beat");

    a_fold_rotate: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FOLD) |=> (state_reg == ST_ROTATE && step_reg == 6'd0))
        else $error("rotation did not start at step zero");

    a_div_sqrt: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && step_reg == DIV_LAST) |=> (state_reg == ST_SQRT_INIT))
        else $error("division did not hand over to square root");

endmodule
`default_nettype wire

FILE: rtl/tlafit_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlafit_dp: datapath of the arm fit error block
// Register bank, angle reduction, two CORDIC lanes, shared multiplier,
// saturating sum, restoring divider, bit-pair square root, result register.
// ----------------------------------------------------------------------------
module tlafit_dp #(
    parameter int MAX_POINTS = tlafit_pkg::MAX_POINTS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    input  wire logic [tlafit_pkg::IDX_W-1:0]      cfg_index,
    input  wire logic [tlafit_pkg::CFG_W-1:0]      cfg_data,
    input  wire logic [tlafit_pkg::S_DATA_W-1:0]   s_tdata,
    input  wire logic                              s_tlast,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [tlafit_pkg::M_DATA_W-1:0]        m_tdata,
    input  wire tlafit_pkg::cmd_t                  cmd,
    output tlafit_pkg::status_t                    status
);
    import tlafit_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int CNT_X = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

    // configuration
    logic [LEN_W-1:0] link_one_reg, link_two_reg, span_x_reg, span_y_reg;
    logic [POS_W-1:0] origin_x_reg, origin_y_reg;
    logic [OFF_W-1:0] off_one_reg, off_two_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_one_reg <= LINK_ONE_RST;
            link_two_reg <= LINK_TWO_RST;
            origin_x_reg <= ORIGIN_X_RST;
            origin_y_reg <= ORIGIN_Y_RST;
            span_x_reg   <= SPAN_X_RST;
            span_y_reg   <= SPAN_Y_RST;
            off_one_reg  <= OFF_ONE_RST;
            off_two_reg  <= OFF_TWO_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_LINK_ONE: link_one_reg <= cfg_data[LEN_W-1:0];
                REG_LINK_TWO: link_two_reg <= cfg_data[LEN_W-1:0];
                REG_ORIGIN_X: origin_x_reg <= cfg_data[POS_W-1:0];
                REG_ORIGIN_Y: origin_y_reg <= cfg_data[POS_W-1:0];
                REG_SPAN_X:   span_x_reg   <= cfg_data[LEN_W-1:0];
                REG_SPAN_Y:   span_y_reg   <= cfg_data[LEN_W-1:0];
                REG_OFF_ONE:  off_one_reg  <= cfg_data[OFF_W-1:0];
                REG_OFF_TWO:  off_two_reg  <= cfg_data[OFF_W-1:0];
                default: ;
            endcase
        end
    end

    // point fields
    logic [GRID_W-1:0] gx_reg, gy_reg;
    logic              last_reg;

    // angle lanes: a = first link, b = second link global angle
    logic signed [ANG_W-1:0] ra_reg, rb_reg;
    logic                    nega_reg, negb_reg;
    logic signed [CW-1:0]    xa_reg, ya_reg, za_reg, xb_reg, yb_reg, zb_reg;

    logic signed [ANG_W-1:0] d1, d2, ra_red, rb_red, ra_fold, rb_fold;
    logic                    nega_fold, negb_fold;

    assign d1 = ANG_W'($signed(s_tdata[29:10])) - ANG_W'($signed(off_one_reg));
    assign d2 = ANG_W'($signed(s_tdata[49:30])) - ANG_W'($signed(off_two_reg));

    always_comb begin
        ra_red = ra_reg;
        if (ra_reg > PI_Q16)       ra_red = ra_reg - TWO_PI_Q16;
        else if (ra_reg < -PI_Q16) ra_red = ra_reg + TWO_PI_Q16;
        rb_red = rb_reg;
        if (rb_reg > PI_Q16)       rb_red = rb_reg - TWO_PI_Q16;
        else if (rb_reg < -PI_Q16) rb_red = rb_reg + TWO_PI_Q16;

        ra_fold = ra_reg;
        nega_fold = 1'b0;
        if (ra_reg > HALF_PI_Q16) begin
            ra_fold = ra_reg - PI_Q16;
            nega_fold = 1'b1;
        end else if (ra_reg < -HALF_PI_Q16) begin
            ra_fold = ra_reg + PI_Q16;
            nega_fold = 1'b1;
        end
        rb_fold = rb_reg;
        negb_fold = 1'b0;
        if (rb_reg > HALF_PI_Q16) begin
            rb_fold = rb_reg - PI_Q16;
            negb_fold = 1'b1;
        end else if (rb_reg < -HALF_PI_Q16) begin
            rb_fold = rb_reg + PI_Q16;
            negb_fold = 1'b1;
        end
    end

    logic [4:0]           rot_i;
    logic signed [CW-1:0] atan_i;
    assign rot_i  = cmd.step[4:0];
    assign atan_i = atan_q30(rot_i);

    // shared multiplier and point arithmetic
    logic signed [34:0]       mul_a;
    logic signed [28:0]       mul_b;
    logic signed [63:0]       prod_reg, acc_reg;
    logic [V_W-1:0]           vx_reg, vy_reg;
    logic [Q_W-1:0]           qx_reg, qy_reg;
    logic signed [EXP_W-1:0]  ex_reg, ey_reg;
    logic signed [ERR_W-1:0]  errx_reg, erry_reg;
    logic signed [CW-1:0]     c1, c2, s1, s2;
    logic [V_W-1:0]           qx28, qy28, remx, remy;
    logic                     corrx, corry;
    logic signed [63:0]       tip_sum, tip;
    logic [53:0]              sq;
    logic [SUM_W:0]           sum_ext;

    assign c1 = nega_reg ? -xa_reg : xa_reg;
    assign s1 = nega_reg ? -ya_reg : ya_reg;
    assign c2 = negb_reg ? -xb_reg : xb_reg;
    assign s2 = negb_reg ? -yb_reg : yb_reg;

    assign qx28  = {3'b000, qx_reg};
    assign qy28  = {3'b000, qy_reg};
    assign remx  = vx_reg - ((qx28 << 4) + (qx28 << 1));
    assign remy  = vy_reg - ((qy28 << 4) + (qy28 << 1));
    assign corrx = remx >= 28'd18;
    assign corry = remy >= 28'd18;

    // round half up from Q38 to Q8
    assign tip_sum = acc_reg + prod_reg + 64'sd536870912;
    assign tip     = tip_sum >>> 30;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.step[3:0])
            4'd0: begin
                mul_a = {30'd0, gx_reg};
                mul_b = {6'd0, span_x_reg};
            end
            4'd1: begin
                mul_a = {30'd0, gy_reg};
                mul_b = {6'd0, span_y_reg};
            end
            4'd2: begin
                mul_a = {7'd0, vx_reg};
                mul_b = RECIP_18;
            end
            4'd3: begin
                mul_a = {7'd0, vy_reg};
                mul_b = RECIP_18;
            end
            4'd4: begin
                mul_a = {c1[CW-1], c1};
                mul_b = {6'd0, link_one_reg};
            end
            4'd5: begin
                mul_a = {c2[CW-1], c2};
                mul_b = {6'd0, link_two_reg};
            end
            4'd6: begin
                mul_a = {s1[CW-1], s1};
                mul_b = {6'd0, link_one_reg};
            end
            4'd7: begin
                mul_a = {s2[CW-1], s2};
                mul_b = {6'd0, link_two_reg};
            end
            4'd8: begin
                mul_a = {{8{errx_reg[ERR_W-1]}}, errx_reg};
                mul_b = {{2{errx_reg[ERR_W-1]}}, errx_reg};
            end
            4'd9: begin
                mul_a = {{8{erry_reg[ERR_W-1]}}, erry_reg};
                mul_b = {{2{erry_reg[ERR_W-1]}}, erry_reg};
            end
            default: ;
        endcase
    end

    // accumulation, division, square root
    logic [SUM_W-1:0]  sum_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [SUM_W-1:0]  divq_reg;
    logic [CNT_W:0]    rem_reg;
    logic [CNT_W-1:0]  divisor;
    logic [CNT_W:0]    rem_try;
    logic [SUM_W-1:0]  sv_reg, res_reg, bit_reg;
    logic [SUM_W:0]    sq_try;

    assign sq      = acc_reg[53:0] + prod_reg[53:0];
    assign sum_ext = {1'b0, sum_reg} + {3'b000, sq};

    assign divisor = (count_reg == '0) ? CNT_W'(1) : count_reg;
    assign rem_try = {rem_reg[CNT_W-1:0], divq_reg[SUM_W-1]};
    assign sq_try  = {1'b0, res_reg} + {1'b0, bit_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            count_reg <= '0;
        end else if (cmd.op == CMD_MUL && cmd.step == MUL_LAST) begin
            sum_reg   <= sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
            count_reg <= count_reg + CNT_W'(1);
        end else if (cmd.op == CMD_EMIT) begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            CMD_LOAD: begin
                gx_reg   <= s_tdata[4:0];
                gy_reg   <= s_tdata[9:5];
                last_reg <= s_tlast;
                ra_reg   <= d1;
                rb_reg   <= d1 - d2;
            end
            CMD_REDUCE: begin
                ra_reg <= ra_red;
                rb_reg <= rb_red;
            end
            CMD_FOLD: begin
                nega_reg <= nega_fold;
                negb_reg <= negb_fold;
                za_reg   <= CW'(ra_fold) <<< 14;
                zb_reg   <= CW'(rb_fold) <<< 14;
                xa_reg   <= GAIN_Q30;
                xb_reg   <= GAIN_Q30;
                ya_reg   <= '0;
                yb_reg   <= '0;
            end
            CMD_ROTATE: begin
                if (!za_reg[CW-1]) begin
                    xa_reg <= xa_reg - (ya_reg >>> rot_i);
                    ya_reg <= ya_reg + (xa_reg >>> rot_i);
                    za_reg <= za_reg - atan_i;
                end else begin
                    xa_reg <= xa_reg + (ya_reg >>> rot_i);
                    ya_reg <= ya_reg - (xa_reg >>> rot_i);
                    za_reg <= za_reg + atan_i;
                end
                if (!zb_reg[CW-1]) begin
                    xb_reg <= xb_reg - (yb_reg >>> rot_i);
                    yb_reg <= yb_reg + (xb_reg >>> rot_i);
                    zb_reg <= zb_reg - atan_i;
                end else begin
                    xb_reg <= xb_reg + (yb_reg >>> rot_i);
                    yb_reg <= yb_reg - (xb_reg >>> rot_i);
                    zb_reg <= zb_reg + atan_i;
                end
            end
            CMD_MUL: begin
                prod_reg <= mul_a * mul_b;
                case (cmd.step[3:0])
                    4'd1: vx_reg <= prod_reg[V_W-1:0] + 28'd9;
                    4'd2: vy_reg <= prod_reg[V_W-1:0] + 28'd9;
                    4'd3: qx_reg <= prod_reg[56:32];
                    4'd4: begin
                        qy_reg <= prod_reg[56:32];
                        ex_reg <= {{2{origin_x_reg[POS_W-1]}}, origin_x_reg}
                                  + {1'b0, qx_reg} + {25'd0, corrx};
                    end
                    4'd5: begin
                        ey_reg  <= {{2{origin_y_reg[POS_W-1]}}, origin_y_reg}
                                   + {1'b0, qy_reg} + {25'd0, corry};
                        acc_reg <= prod_reg;
                    end
                    4'd6: errx_reg <= ERR_W'(tip - 64'(ex_reg));
                    4'd7: acc_reg  <= prod_reg;
                    4'd8: erry_reg <= ERR_W'(tip - 64'(ey_reg));
                    4'd9: acc_reg  <= prod_reg;
                    default: ;
                endcase
            end
            CMD_DIV_INIT: begin
                divq_reg <= sum_reg;
                rem_reg  <= '0;
            end
            CMD_DIV: begin
                if (rem_try >= {1'b0, divisor}) begin
                    rem_reg  <= rem_try - {1'b0, divisor};
                    divq_reg <= {divq_reg[SUM_W-2:0], 1'b1};
                end else begin
                    rem_reg  <= rem_try;
                    divq_reg <= {divq_reg[SUM_W-2:0], 1'b0};
                end
            end
            CMD_SQRT_INIT: begin
                sv_reg  <= divq_reg;
                res_reg <= '0;
                bit_reg <= {2'b01, {(SUM_W-2){1'b0}}};
            end
            CMD_SQRT: begin
                if ({1'b0, sv_reg} >= sq_try) begin
                    sv_reg  <= sv_reg - sq_try[SUM_W-1:0];
                    res_reg <= (res_reg >> 1) + bit_reg;
                end else begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            default: ;
        endcase
    end

    // result register
    logic [SUM_W-1:0]   rms_full;
    logic [RMS_W-1:0]   rms_sat;
    logic [CNT_X-1:0]   cnt_ext;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg;

    assign rms_full = res_reg + {{(SUM_W-1){1'b0}}, (sv_reg > res_reg)};
    assign rms_sat  = (rms_full > {{(SUM_W-RMS_W){1'b0}}, RMS_MAX})
                      ? RMS_MAX : rms_full[RMS_W-1:0];
    assign cnt_ext  = CNT_X'(count_reg);

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.op == CMD_EMIT)  m_tvalid_next = 1'b1;
        else if (m_tready)       m_tvalid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == CMD_EMIT) begin
            m_tdata_reg <= {cnt_ext[CNT_OUT_W-1:0], rms_sat};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign status.reduce_done = !(ra_reg > PI_Q16) && !(ra_reg < -PI_Q16)
                                && !(rb_reg > PI_Q16) && !(rb_reg < -PI_Q16);
    assign status.full        = count_reg >= CNT_MAX;
    assign status.last        = last_reg;
    assign status.out_free    = !m_tvalid_reg || m_tready;

endmodule
`default_nettype wire

FILE: rtl/two_link_arm_fit_rms_error_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// two_link_arm_fit_rms_error_top: RMS tip error of a two-link arm fit
// Forward kinematics per calibration point, saturating squared-error sum,
// RMS result and point count on the point marked last.
// ----------------------------------------------------------------------------
// Point: load, angle reduction, fold, CORDIC_STEPS rotation steps, 11
//   multiply phases and check, in that order, on the shared multiplier and the
//   iterative CORDIC; with MAX_POINTS taken, a point goes from load to check.
// Last point: divider init, 56 divider steps, root init, 28 root steps, emit; the
//   result beat waits in the output register; a new point is taken meanwhile.
// Reset (aresetn low, synchronous) restores the registers to their defaults,
//   clears the sum, the point count and the result beat valid.
module two_link_arm_fit_rms_error_top #(
    parameter int MAX_POINTS   = tlafit_pkg::MAX_POINTS_DEF,
    parameter int CORDIC_STEPS = tlafit_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // configuration writes
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [tlafit_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [tlafit_pkg::CFG_W-1:0]    cfg_data,
    // point beats
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // grid_x[4:0], grid_y[9:5], first_angle[29:10], second_angle[49:30], zero fill
    input  wire logic [tlafit_pkg::S_DATA_W-1:0] s_tdata,
    input  wire logic                            s_tlast,     // last_point
    // result beats
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // rms_error[22:0], point_count[31:23]
    output logic [tlafit_pkg::M_DATA_W-1:0]      m_tdata
);
    import tlafit_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    cfg_fire;

    // registers always accept; writes must come only while idle, which the block does not enforce
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;

    tlafit_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tlafit_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_fire),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
`default_nettype wire

FILE: tb/sv/tb_two_link_arm_fit_rms_error_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_two_link_arm_fit_rms_error_top: self-checking bench for the arm fit block
// Drives calibration point beats and register writes, predicts the RMS error
// and point count per set in a behavioural model, checks every result beat.
// ----------------------------------------------------------------------------
module tb_two_link_arm_fit_rms_error_top;
    import tlafit_pkg::*;

    typedef struct packed {
        logic [CNT_OUT_W-1:0] cnt;
        logic [RMS_W-1:0]     rms;
    } fit_result_t;

    localparam longint TWO_PI_L  = 411775;
    localparam longint PI_L      = 205887;
    localparam longint HALF_PI_L = 102944;
    localparam longint SUM_SAT   = (64'd1 << 56) - 1;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    // predictor state: register shadow, square sum, points taken
    logic [23:0]    arm_reg [8];
    longint unsigned sq_sum;
    int             pts_taken;
    fit_result_t    rms_due [$];
    int             n_fail = 0;
    bit             src_idle_en = 1'b1;
    bit             snk_idle_en = 1'b1;
    int             snk_hold = 0;

    // 4 ns high, 4 ns low
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    two_link_arm_fit_rms_error_top i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    function automatic longint sx(longint unsigned v, int w);
        longint unsigned m;
        m = v & ((64'd1 << w) - 1);
        if (m[w-1]) return longint'(m) - (longint'(1) << w);
        return longint'(m);
    endfunction

    function automatic longint asr_floor(longint v, int s);
        if (v >= 0) return v >>> s;
        return -(((-v) - 1) >>> s) - 1;
    endfunction

    // reduce, fold into +-pi/2, iterative rotation; C-style truncating modulo
    task automatic cordic_cs(input longint ang, output longint c, output longint s);
        longint r, x, y, z, dx, dy;
        bit flip;
        logic signed [CW-1:0] at;
        r = ang % TWO_PI_L;
        flip = 1'b0;
        x = 652032874;
        y = 0;
        if (r > PI_L) r -= TWO_PI_L;
        if (r < -PI_L) r += TWO_PI_L;
        if (r > HALF_PI_L) begin
            r -= PI_L; flip = 1'b1;
        end else if (r < -HALF_PI_L) begin
            r += PI_L; flip = 1'b1;
        end
        z = r * 16384;
        for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
            at = atan_q30(i[4:0]);
            dx = asr_floor(y, i);
            dy = asr_floor(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(at);
            end else begin
                x += dx; y -= dy; z += longint'(at);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic longint unsigned isqrt_rnd(longint unsigned v);
        longint unsigned res, bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > v) bt >>= 2;
        while (bt != 0) begin
            if (v >= res + bt) begin
                v -= res + bt; res = (res >> 1) + bt;
            end else res >>= 1;
            bt >>= 2;
        end
        if (v > res) res++;
        return res;
    endfunction

    task automatic predict_point(input logic [4:0] gx, input logic [4:0] gy,
                                 input logic [19:0] a1, input logic [19:0] a2,
                                 input bit lst);
        longint d1, d2, c1, s1, c2, s2, px, py, ex, ey, erx, ery;
        longint l1, l2;
        longint unsigned sq, n, r;
        fit_result_t res;
        if (pts_taken < MAX_POINTS_DEF) begin
            l1 = arm_reg[REG_LINK_ONE];
            l2 = arm_reg[REG_LINK_TWO];
            d1 = sx(a1, 20) - sx(arm_reg[REG_OFF_ONE], 20);
            d2 = sx(a2, 20) - sx(arm_reg[REG_OFF_TWO], 20);
            cordic_cs(d1, c1, s1);
            cordic_cs(d1 - d2, c2, s2);
            px = asr_floor(l1 * c1 + l2 * c2 + (longint'(1) << 29), 30);
            py = asr_floor(l1 * s1 + l2 * s2 + (longint'(1) << 29), 30);
            ex = sx(arm_reg[REG_ORIGIN_X], 24)
                 + longint'((longint'(gx) * arm_reg[REG_SPAN_X] + 9) / 18);
            ey = sx(arm_reg[REG_ORIGIN_Y], 24)
                 + longint'((longint'(gy) * arm_reg[REG_SPAN_Y] + 9) / 18);
            erx = px - ex;
            ery = py - ey;
            sq = longint'(erx * erx) + longint'(ery * ery);
            sq_sum += sq;
            if (sq_sum > SUM_SAT) sq_sum = SUM_SAT;
            pts_taken++;
        end
        if (lst) begin
            n = pts_taken ? pts_taken : 1;
            r = isqrt_rnd(sq_sum / n);
            if (r > 64'd8388607) r = 64'd8388607;
            res.rms = r[RMS_W-1:0];
            res.cnt = pts_taken[CNT_OUT_W-1:0];
            rms_due.push_back(res);
            sq_sum = 0;
            pts_taken = 0;
        end
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx < 8) arm_reg[idx] = val & ((idx inside {[REG_ORIGIN_X:REG_ORIGIN_Y]}) ?
            24'hFFFFFF : (idx >= REG_OFF_ONE ? 24'h0FFFFF : 24'h7FFFFF));
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // one point beat, with optional random gap before it
    task automatic send_point(input logic [4:0] gx, input logic [4:0] gy,
                              input logic [19:0] a1, input logic [19:0] a2,
                              input bit lst);
        int gap;
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 10);
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= {6'd0, a2, a1, gy, gx};
        s_tlast  <= lst;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_point(gx, gy, a1, a2, lst);
        @(negedge aclk);
    endtask

    task automatic stop_src();
        s_tvalid <= 1'b0;
    endtask

    // wait until all results are back plus the block's longest tail
    task automatic drain();
        stop_src();
        while (rms_due.size() != 0) @(negedge aclk);
        repeat (150) @(negedge aclk);
    endtask

    // result checker, sampled on the rising edge
    always @(posedge aclk) begin
        fit_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[RMS_W+CNT_OUT_W-1:0];
            if (rms_due.size() == 0) begin
                $error("unexpected result beat rms_error=%0d", got.rms);
                n_fail++;
            end else begin
                want = rms_due.pop_front();
                if (got.rms !== want.rms) begin
                    $error("rms_error expected %0d actual %0d", want.rms, got.rms);
                    n_fail++;
                end
                if (got.cnt !== want.cnt) begin
                    $error("point_count expected %0d actual %0d", want.cnt, got.cnt);
                    n_fail++;
                end
            end
        end
    end

    // receiver ready: random bursts of idling, or a long counted hold-off
    always @(negedge aclk) begin
        if (snk_hold > 0) begin
            snk_hold <= snk_hold - 1;
            m_tready <= 1'b0;
        end else if (snk_idle_en) m_tready <= ($urandom_range(0, 2) != 0);
        else m_tready <= 1'b1;
    end

    function automatic logic [19:0] rnd_ang();
        case ($urandom_range(0, 5))
            0: return 20'h80000;
            1: return 20'h7FFFF;
            default: return 20'($urandom());
        endcase
    endfunction

    task automatic test_directed();
        send_point(5'd0, 5'd0, 20'd0, 20'd0, 1'b1);
        send_point(5'd18, 5'd18, 20'h7FFFF, 20'h80000, 1'b0);
        send_point(5'd31, 5'd31, 20'h80000, 20'h7FFFF, 1'b1);
        // folding either side of +-pi/2 and +-pi
        send_point(5'd9, 5'd3, 20'd102944 + 20'd102945, 20'd205887, 1'b0);
        send_point(5'd9, 5'd3, 20'd102944 - 20'd102945, 20'd0, 1'b0);
        send_point(5'd1, 5'd17, 20'd102944 + 20'd205888, 20'd411775, 1'b1);
        send_point(5'd2, 5'd5, 20'hFFFFF, 20'h00001, 1'b1);
        drain();
    endtask

    task automatic test_extreme_cfg();
        // large lengths and offsets push sum and rms towards saturation
        write_reg(REG_LINK_ONE, 24'h7FFFFF);
        write_reg(REG_LINK_TWO, 24'h7FFFFF);
        write_reg(REG_ORIGIN_X, 24'h800000);
        write_reg(REG_ORIGIN_Y, 24'h7FFFFF);
        write_reg(REG_SPAN_X, 24'h7FFFFF);
        write_reg(REG_SPAN_Y, 24'd0);
        write_reg(REG_OFF_ONE, 24'h080000);
        write_reg(REG_OFF_TWO, 24'h07FFFF);
        write_reg(4'd9, 24'h123456);
        write_reg(4'd15, 24'hFFFFFF);
        for (int i = 0; i < 6; i++)
            send_point(5'($urandom()), 5'($urandom()), rnd_ang(), rnd_ang(), i == 5);
        send_point(5'd31, 5'd0, 20'h80000, 20'h80000, 1'b1);
        drain();
        write_reg(REG_LINK_ONE, 24'd0);
        write_reg(REG_LINK_TWO, 24'd0);
        write_reg(REG_ORIGIN_X, 24'd0);
        write_reg(REG_ORIGIN_Y, 24'd0);
        write_reg(REG_SPAN_X, 24'd0);
        write_reg(REG_SPAN_Y, 24'h7FFFFF);
        write_reg(REG_OFF_ONE, 24'd0);
        write_reg(REG_OFF_TWO, 24'h080000);
        send_point(5'd0, 5'd0, 20'd0, 20'd0, 1'b1);
        send_point(5'd18, 5'd31, 20'd5, 20'd7, 1'b1);
        drain();
    endtask

    // sets beyond MAX_POINTS: overflowing points are dropped, count stops at MAX_POINTS
    task automatic test_point_overflow();
        for (int i = 0; i < 260; i++)
            send_point(5'($urandom_range(0, 18)), 5'($urandom_range(0, 18)),
                       20'($urandom()), 20'($urandom()), i == 259);
        for (int i = 0; i < 256; i++)
            send_point(5'($urandom_range(0, 18)), 5'($urandom_range(0, 18)),
                       20'($urandom()), 20'($urandom()), i == 255);
        drain();
    endtask

    task automatic rnd_cfg();
        write_reg(REG_LINK_ONE, 24'($urandom_range(0, 200000)));
        write_reg(REG_LINK_TWO, 24'($urandom_range(0, 200000)));
        write_reg(REG_ORIGIN_X, 24'($urandom()));
        write_reg(REG_ORIGIN_Y, 24'($urandom()));
        write_reg(REG_SPAN_X, 24'($urandom_range(0, 200000)));
        write_reg(REG_SPAN_Y, 24'($urandom_range(0, 200000)));
        write_reg(REG_OFF_ONE, 24'($urandom()));
        write_reg(REG_OFF_TWO, 24'($urandom()));
    endtask

    task automatic test_random_sets(input int n_items, input bit hold_sink);
        int left;
        bit lst;
        left = n_items;
        if (hold_sink) snk_hold = 400;
        while (left > 0) begin
            // mostly short sets, sometimes a longer one
            lst = ($urandom_range(0, 9) < 3) || left == 1;
            send_point(5'($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 18)),
                       5'($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 18)),
                       rnd_ang(), rnd_ang(), lst);
            left--;
        end
        drain();
    endtask

    initial begin
        arm_reg[0] = LINK_ONE_RST; arm_reg[1] = LINK_TWO_RST;
        arm_reg[2] = ORIGIN_X_RST; arm_reg[3] = ORIGIN_Y_RST;
        arm_reg[4] = SPAN_X_RST;   arm_reg[5] = SPAN_Y_RST;
        arm_reg[6] = OFF_ONE_RST;  arm_reg[7] = OFF_TWO_RST;
        sq_sum = 0;
        pts_taken = 0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_extreme_cfg();
        rnd_cfg();
        test_point_overflow();
        // long sink hold-off while points keep coming
        test_random_sets(60, 1'b1);
        for (int p = 0; p < 4; p++) begin
            rnd_cfg();
            test_random_sets(200, 1'b0);
        end
        write_reg(REG_LINK_ONE, LINK_ONE_RST);
        write_reg(REG_LINK_TWO, LINK_TWO_RST);
        write_reg(REG_ORIGIN_X, ORIGIN_X_RST);
        write_reg(REG_ORIGIN_Y, ORIGIN_Y_RST);
        write_reg(REG_SPAN_X, SPAN_X_RST);
        write_reg(REG_SPAN_Y, SPAN_Y_RST);
        write_reg(REG_OFF_ONE, OFF_ONE_RST);
        write_reg(REG_OFF_TWO, OFF_TWO_RST);
        test_random_sets(200, 1'b0);
        // last part at full rate, no idling
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        test_random_sets(150, 1'b0);
        if (n_fail == 0) $display("PASSED: all results match");
        else $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
